>>> rtl/register_file_alu_core_defines.svh
// Assertion macros used by the RTL file register_file_alu_core.sv.
`ifndef REGISTER_FILE_ALU_CORE_DEFINES_SVH
`define REGISTER_FILE_ALU_CORE_DEFINES_SVH

// Same-cycle implication.
`define RFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rfa_pkg.sv
package rfa_pkg;

  localparam int WORD_W        = 32;
  localparam int IDX_W         = 3;
  localparam int MODE_W        = 3;
  localparam int REG_COUNT_DEF = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CMOV = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_NAND = 3'd4,
    MODE_LOAD = 3'd5
  } mode_t;

endpackage

>>> rtl/rfa_div.sv
module rfa_div #(
  parameter int W = rfa_pkg::WORD_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/register_file_alu_core.sv
// Register-machine execution unit with REGISTER_COUNT 32-bit registers held in a
// two-read, one-write synchronous memory; per-entry valid bits make every register
// read as zero after reset, so no clearing pass is needed. One word is taken at a
// time: move, add, multiply, nand, load, unused modes and a divide by zero pass from
// accept to result through operand read, execute and write back; a divide with a
// nonzero divisor waits in between for the one-bit-per-cycle restoring divider.
// A new word is accepted while the previous result still waits in the output register.
`include "register_file_alu_core_defines.svh"

module register_file_alu_core #(
  parameter int REGISTER_COUNT = rfa_pkg::REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // dest_index, first_source, second_source, load_value, zero pad
  input  logic [47:0] in_tdata,
  // mode
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // written_index, result_value, zero pad
  output logic [39:0] out_tdata,
  // was_written, divide_by_zero
  output logic [1:0]  out_tuser
);

  localparam int W  = rfa_pkg::WORD_W;
  localparam int IW = rfa_pkg::IDX_W;
  localparam int AW = $clog2(REGISTER_COUNT);
  localparam int EW = AW + IW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OP   = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [W-1:0] mem_r [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_r;

  logic [IW-1:0] in_dst, in_fsrc, in_ssrc;
  logic [W-1:0]  in_imm;
  logic          in_acc;

  logic [2:0]    mode_r;
  logic [IW-1:0] dst_r;
  logic [W-1:0]  imm_r;
  logic          dst_ok_r;

  logic [IW-1:0] ra_idx;
  logic [EW-1:0] ra_ext, rb_ext;
  logic          ra_ok, rb_ok;
  logic [W-1:0]  rd_a_r, rd_b_r;
  logic          rd_a_ok_r, rd_b_ok_r;

  logic [W-1:0]  opx, opy;
  logic [W-1:0]  value_r, value_nxt;
  logic          wr_r, wr_nxt;
  logic          dz_r, dz_nxt;
  logic [2*W-1:0] prod;

  logic          div_start, div_done;
  logic [W-1:0]  div_quo;

  logic          out_free, fin_go;
  logic [EW-1:0] dst_ext;
  logic [AW-1:0] dst_addr;

  logic          out_valid_r;
  logic [IW-1:0] out_idx_r;
  logic [W-1:0]  out_val_r;
  logic          out_wr_r, out_dz_r;

  assign in_dst  = in_tdata[2:0];
  assign in_fsrc = in_tdata[5:3];
  assign in_ssrc = in_tdata[8:6];
  assign in_imm  = in_tdata[40:9];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // port a: first source at accept, destination afterwards
  assign ra_idx = (state_r == ST_IDLE) ? in_fsrc : dst_r;
  assign ra_ext = {{AW{1'b0}}, ra_idx};
  assign rb_ext = {{AW{1'b0}}, in_ssrc};
  assign ra_ok  = (ra_ext < EW'(REGISTER_COUNT)) && vld_r[ra_ext[AW-1:0]];
  assign rb_ok  = (rb_ext < EW'(REGISTER_COUNT)) && vld_r[rb_ext[AW-1:0]];

  always_ff @(posedge clk) begin
    rd_a_r    <= mem_r[ra_ext[AW-1:0]];
    rd_b_r    <= mem_r[rb_ext[AW-1:0]];
    rd_a_ok_r <= ra_ok;
    rd_b_ok_r <= rb_ok;
  end

  assign opx  = rd_a_ok_r ? rd_a_r : '0;
  assign opy  = rd_b_ok_r ? rd_b_r : '0;
  assign prod = opx * opy;

  assign out_free = !out_valid_r || out_tready;
  assign fin_go   = (state_r == ST_FIN) && out_free;
  assign dst_ext  = {{AW{1'b0}}, dst_r};
  assign dst_addr = dst_ext[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    wr_nxt    = wr_r;
    dz_nxt    = dz_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_OP;
        end
      end
      ST_OP: begin
        value_nxt = '0;
        wr_nxt    = 1'b0;
        dz_nxt    = 1'b0;
        state_nxt = ST_FIN;
        case (mode_r)
          rfa_pkg::MODE_CMOV: begin
            value_nxt = opx;
            wr_nxt    = (opy != '0);
          end
          rfa_pkg::MODE_ADD: begin
            value_nxt = opx + opy;
            wr_nxt    = 1'b1;
          end
          rfa_pkg::MODE_MUL: begin
            value_nxt = prod[W-1:0];
            wr_nxt    = 1'b1;
          end
          rfa_pkg::MODE_DIV: begin
            if (opy == '0) begin
              dz_nxt = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
          rfa_pkg::MODE_NAND: begin
            value_nxt = ~(opx & opy);
            wr_nxt    = 1'b1;
          end
          rfa_pkg::MODE_LOAD: begin
            value_nxt = imm_r;
            wr_nxt    = 1'b1;
          end
          default: begin
            wr_nxt = 1'b0;
          end
        endcase
        wr_nxt = wr_nxt && dst_ok_r;
      end
      ST_DIV: begin
        if (div_done) begin
          value_nxt = div_quo;
          wr_nxt    = dst_ok_r;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  rfa_div #(
    .W(W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (opx),
    .divisor  (opy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go && wr_r) begin
        vld_r[dst_addr] <= 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && wr_r) begin
      mem_r[dst_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    wr_r    <= wr_nxt;
    dz_r    <= dz_nxt;
    if (in_acc) begin
      mode_r   <= in_tuser;
      dst_r    <= in_dst;
      imm_r    <= in_imm;
      dst_ok_r <= ({{AW{1'b0}}, in_dst} < EW'(REGISTER_COUNT));
    end
    if (fin_go) begin
      out_idx_r <= dst_r;
      out_val_r <= wr_r ? value_r : (rd_a_ok_r ? rd_a_r : '0);
      out_wr_r  <= wr_r;
      out_dz_r  <= dz_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_val_r, out_idx_r};
  assign out_tuser  = {out_dz_r, out_wr_r};

  `RFA_ASSERT_NOW(a_dz_no_write, out_valid_r && out_dz_r, !out_wr_r,
    "divide by zero reported with a register write")
  `RFA_ASSERT_NOW(a_div_done_state, div_done, state_r == ST_DIV,
    "divider finished outside the divide wait")
  `RFA_ASSERT_NEXT(a_fin_hold, (state_r == ST_FIN) && out_valid_r && !out_tready,
    state_r == ST_FIN, "write back left while the output was blocked")
  `RFA_ASSERT_NEXT(a_write_valid, fin_go && wr_r, vld_r[dst_addr],
    "written register not marked valid")

endmodule
